// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the stuck task detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define STKDET_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define STKDET_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/stkdet_pkg.sv =====
// ----------------------------------------------------------------------------
// stkdet_pkg
// Types and constants shared by the stuck task detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stkdet_pkg;

    localparam int SLOT_W      = 5;
    localparam int TABLE_SLOTS = 2 ** SLOT_W;
    localparam int CNT_W       = SLOT_W + 1;

    localparam int ID_W    = 15;
    localparam int STATE_W = 4;
    localparam int TICKS_W = 32;
    localparam int ENTRY_W = 32;
    localparam int COUNT_W = 8;
    localparam int LIMIT_W = 5;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] NORMAL_THR_RST   = 8'd10;
    localparam logic [COUNT_W-1:0] RESERVED_THR_RST = 8'd100;
    localparam logic [STATE_W-1:0] FIRST_WAIT_RST   = 4'd4;
    localparam logic [LIMIT_W-1:0] STATE_LIMIT_RST  = 5'd12;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

    typedef enum logic [1:0] {
        REG_NORMAL_THR   = 2'd0,
        REG_RESERVED_THR = 2'd1,
        REG_FIRST_WAIT   = 2'd2,
        REG_STATE_LIMIT  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [COUNT_W-1:0] normal_thr;
        logic [COUNT_W-1:0] reserved_thr;
        logic [STATE_W-1:0] first_wait;
        logic [LIMIT_W-1:0] state_limit;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [STATE_W-1:0] state;
        logic [TICKS_W-1:0] ticks;
        logic [COUNT_W-1:0] count;
    } slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_UPDATE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic probe;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic probe_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/stuck_task_detector.sv =====
// Stuck task detector, sequential: one sample at a time.
// Flow: the sample is captured, the probe walk reads one slot per cycle along the
//   path through every slot, then the table is updated and the result registered
//   once the output is free; a new sample is accepted only after that.
// Reset: synchronous, active low; slot valid bits clear and registers return
//   to their defaults.
// ----------------------------------------------------------------------------
// stuck_task_detector
// Top level: APB registers, sequencer and slot table datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module stuck_task_detector import stkdet_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ID_W-1:0]       s_task_id,
    input  wire logic [STATE_W-1:0]    s_task_state,
    input  wire logic [TICKS_W-1:0]    s_active_ticks,
    input  wire logic                  s_load_valid,
    input  wire logic                  s_reserved_task,
    input  wire logic [ENTRY_W-1:0]    s_entry_address,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_stuck_report,
    output logic      [ID_W-1:0]       m_stuck_id,
    output logic      [STATE_W-1:0]    m_stuck_state,
    output logic      [ENTRY_W-1:0]    m_stuck_entry,
    output logic                       m_table_full
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    stkdet_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stkdet_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    stkdet_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .s_task_id       (s_task_id),
        .s_task_state    (s_task_state),
        .s_active_ticks  (s_active_ticks),
        .s_load_valid    (s_load_valid),
        .s_reserved_task (s_reserved_task),
        .s_entry_address (s_entry_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_stuck_report  (m_stuck_report),
        .m_stuck_id      (m_stuck_id),
        .m_stuck_state   (m_stuck_state),
        .m_stuck_entry   (m_stuck_entry),
        .m_table_full    (m_table_full)
    );

endmodule

`default_nettype wire

// ===== rtl/stkdet_regs.sv =====
// ----------------------------------------------------------------------------
// stkdet_regs
// APB configuration registers: thresholds and waiting state range.
// ----------------------------------------------------------------------------
`default_nettype none

module stkdet_regs import stkdet_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_NORMAL_THR:   cfg_next.normal_thr   = pwdata[COUNT_W-1:0];
                REG_RESERVED_THR: cfg_next.reserved_thr = pwdata[COUNT_W-1:0];
                REG_FIRST_WAIT:   cfg_next.first_wait   = pwdata[STATE_W-1:0];
                REG_STATE_LIMIT:  cfg_next.state_limit  = pwdata[LIMIT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_NORMAL_THR:   prdata = APB_DATA_W'(cfg_reg.normal_thr);
            REG_RESERVED_THR: prdata = APB_DATA_W'(cfg_reg.reserved_thr);
            REG_FIRST_WAIT:   prdata = APB_DATA_W'(cfg_reg.first_wait);
            REG_STATE_LIMIT:  prdata = APB_DATA_W'(cfg_reg.state_limit);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.normal_thr   <= NORMAL_THR_RST;
            cfg_reg.reserved_thr <= RESERVED_THR_RST;
            cfg_reg.first_wait   <= FIRST_WAIT_RST;
            cfg_reg.state_limit  <= STATE_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stkdet_ctrl.sv =====
// ----------------------------------------------------------------------------
// stkdet_ctrl
// Sequencer: accept a sample, walk the probe path, then update and report.
// ----------------------------------------------------------------------------
`default_nettype none

module stkdet_ctrl import stkdet_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                cmd.probe = 1'b1;
                if (status.probe_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/stkdet_dpath.sv =====
// ----------------------------------------------------------------------------
// stkdet_dpath
// Slot table, probe walk, count update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stkdet_dpath import stkdet_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire ctrl_cmd_t          cmd,
    output dp_status_t              status,
    input  wire logic [ID_W-1:0]    s_task_id,
    input  wire logic [STATE_W-1:0] s_task_state,
    input  wire logic [TICKS_W-1:0] s_active_ticks,
    input  wire logic               s_load_valid,
    input  wire logic               s_reserved_task,
    input  wire logic [ENTRY_W-1:0] s_entry_address,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_stuck_report,
    output logic      [ID_W-1:0]    m_stuck_id,
    output logic      [STATE_W-1:0] m_stuck_state,
    output logic      [ENTRY_W-1:0] m_stuck_entry,
    output logic                    m_table_full
);

    // captured sample
    logic [ID_W-1:0]    id_reg;
    logic [STATE_W-1:0] st_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic               load_reg;
    logic               rsv_reg;
    logic [ENTRY_W-1:0] entry_reg;

    // slot table
    slot_t              slot_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] vld_reg;
    slot_t              rdat_reg;
    logic               rvld_reg;

    // probe walk
    logic [CNT_W-1:0]   iss_k_reg;
    logic               chk_vld_reg;
    logic               chk_last_reg;
    logic [SLOT_W-1:0]  chk_slot_reg;
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic [ID_W-1:0]    ent_id;

    // search results
    logic               hit_reg;
    logic [SLOT_W-1:0]  hit_slot_reg;
    logic [STATE_W-1:0] hit_state_reg;
    logic [TICKS_W-1:0] hit_ticks_reg;
    logic [COUNT_W-1:0] hit_count_reg;
    logic               empty_found_reg;
    logic [SLOT_W-1:0]  empty_slot_reg;

    // update
    logic               waiting;
    logic               same;
    logic [COUNT_W-1:0] thr;
    logic [COUNT_W-1:0] cnt_inc;
    logic               wr_en;
    logic               set_vld;
    logic               clr_vld;
    logic [SLOT_W-1:0]  wr_addr;
    slot_t              wr_data;
    logic               rep;
    logic               full;

    // result register
    logic               m_valid_reg;
    logic               m_report_reg;
    logic [ID_W-1:0]    m_id_reg;
    logic [STATE_W-1:0] m_state_reg;
    logic [ENTRY_W-1:0] m_entry_reg;
    logic               m_full_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            id_reg    <= s_task_id;
            st_reg    <= s_task_state;
            ticks_reg <= s_active_ticks;
            load_reg  <= s_load_valid;
            rsv_reg   <= s_reserved_task;
            entry_reg <= s_entry_address;
        end
    end

    assign rd_en   = cmd.probe && (iss_k_reg != CNT_W'(TABLE_SLOTS));
    assign rd_addr = id_reg[SLOT_W-1:0] + iss_k_reg[SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_k_reg    <= '0;
            chk_vld_reg  <= 1'b0;
            chk_last_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                iss_k_reg <= '0;
            end else if (rd_en) begin
                iss_k_reg <= iss_k_reg + CNT_W'(1);
            end
            chk_vld_reg  <= rd_en;
            chk_last_reg <= rd_en && (iss_k_reg == CNT_W'(TABLE_SLOTS - 1));
        end
    end

    always_ff @(posedge aclk) begin
        chk_slot_reg <= rd_addr;
        rdat_reg     <= slot_mem[rd_addr];
        rvld_reg     <= vld_reg[rd_addr];
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (set_vld) begin
            vld_reg[wr_addr] <= 1'b1;
        end else if (clr_vld) begin
            vld_reg[wr_addr] <= 1'b0;
        end
    end

    assign ent_id            = rvld_reg ? rdat_reg.id : '0;
    assign status.probe_done = chk_vld_reg && chk_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg         <= 1'b0;
            empty_found_reg <= 1'b0;
        end else if (cmd.capture) begin
            hit_reg         <= 1'b0;
            empty_found_reg <= 1'b0;
        end else if (chk_vld_reg) begin
            if (!hit_reg && ent_id == id_reg) begin
                hit_reg <= 1'b1;
            end
            if (!empty_found_reg && ent_id == '0) begin
                empty_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (chk_vld_reg && !hit_reg && ent_id == id_reg) begin
            hit_slot_reg  <= chk_slot_reg;
            hit_state_reg <= rdat_reg.state;
            hit_ticks_reg <= rdat_reg.ticks;
            hit_count_reg <= rdat_reg.count;
        end
        if (chk_vld_reg && !empty_found_reg && ent_id == '0) begin
            empty_slot_reg <= chk_slot_reg;
        end
    end

    assign waiting = ({1'b0, st_reg} >= {1'b0, cfg.first_wait})
                  && ({1'b0, st_reg} < cfg.state_limit);
    assign same    = (hit_state_reg == st_reg) && (hit_ticks_reg == ticks_reg);
    assign thr     = rsv_reg ? cfg.reserved_thr : cfg.normal_thr;
    assign cnt_inc = (hit_count_reg == COUNT_MAX) ? hit_count_reg
                                                  : hit_count_reg + COUNT_W'(1);

    always_comb begin
        wr_en         = 1'b0;
        set_vld       = 1'b0;
        clr_vld       = 1'b0;
        wr_addr       = hit_slot_reg;
        wr_data.id    = id_reg;
        wr_data.state = st_reg;
        wr_data.ticks = ticks_reg;
        wr_data.count = COUNT_W'(1);
        rep           = 1'b0;
        full          = 1'b0;
        if (id_reg != '0) begin
            if (waiting) begin
                if (load_reg) begin
                    if (hit_reg) begin
                        if (same) begin
                            if (cnt_inc >= thr) begin
                                rep     = 1'b1;
                                clr_vld = 1'b1;
                            end else begin
                                wr_en         = 1'b1;
                                wr_data.count = cnt_inc;
                            end
                        end else begin
                            wr_en = 1'b1;
                        end
                    end else if (empty_found_reg) begin
                        wr_en   = 1'b1;
                        set_vld = 1'b1;
                        wr_addr = empty_slot_reg;
                    end else begin
                        full = 1'b1;
                    end
                end
            end else if (hit_reg) begin
                clr_vld = 1'b1;
            end
        end
        if (!cmd.update) begin
            wr_en   = 1'b0;
            set_vld = 1'b0;
            clr_vld = 1'b0;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.update) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            m_report_reg <= rep;
            m_id_reg     <= rep ? id_reg : '0;
            m_state_reg  <= rep ? st_reg : '0;
            m_entry_reg  <= rep ? entry_reg : '0;
            m_full_reg   <= full;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_stuck_report = m_report_reg;
    assign m_stuck_id     = m_id_reg;
    assign m_stuck_state  = m_state_reg;
    assign m_stuck_entry  = m_entry_reg;
    assign m_table_full   = m_full_reg;

    `STKDET_NEVER(a_report_and_full, aclk, aresetn, m_valid_reg && m_report_reg && m_full_reg, "report and table full together")
    `STKDET_ASSERT(a_report_id, aclk, aresetn, (m_valid_reg && m_report_reg) |-> (m_id_reg != '0), "report with zero id")
    `STKDET_ASSERT(a_update_result, aclk, aresetn, cmd.update |=> m_valid_reg, "update without result")
    `STKDET_NEVER(a_write_in_probe, aclk, aresetn, cmd.probe && (wr_en || set_vld || clr_vld), "table write during probe")

endmodule

`default_nettype wire
